### sv/rau_pkg.sv
// rau_pkg: shared types and codes for the rational arithmetic unit
// used by rau_ctrl, rau_dp and rational_arithmetic_unit; no dependencies
package rau_pkg;

  // opcodes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_RED = 3'd4;
  localparam logic [2:0] OP_NEG = 3'd5;

  // order codes
  localparam logic [1:0] ORD_LESS  = 2'd0;
  localparam logic [1:0] ORD_EQUAL = 2'd1;
  localparam logic [1:0] ORD_GREAT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL,
    CMD_SEL,
    CMD_GCD,
    CMD_DIVN_INIT,
    CMD_DIV_STEP,
    CMD_DIVD_INIT,
    CMD_DIVD_DONE,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e       code;
    logic [1:0] mul_sel;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic gcd_done;
  } stat_t;

endpackage

### sv/rau_ctrl.sv
// rau_ctrl: sequencer for the rational arithmetic unit
// drives rau_dp through cmd_t and reads stat_t; depends on rau_pkg
module rau_ctrl import rau_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  localparam int PW = 2 * WORD_BITS;
  localparam int CW = $clog2(PW);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_SEL    = 4'd2;
  localparam logic [3:0] S_GCD    = 4'd3;
  localparam logic [3:0] S_DIVN   = 4'd4;
  localparam logic [3:0] S_DIVD   = 4'd5;
  localparam logic [3:0] S_DDONE  = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_DSTORE = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  // next state and command
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_o.code    = CMD_NONE;
    cmd_o.mul_sel = cnt_q[1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.code = CMD_LOAD;
          cnt_d      = '0;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.code = CMD_MUL;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CW'(3)) state_d = S_SEL;
      end
      S_SEL: begin
        cmd_o.code = CMD_SEL;
        state_d    = stat_i.err ? S_FIN : S_GCD;
      end
      S_GCD: begin
        if (stat_i.gcd_done) begin
          cmd_o.code = CMD_DIVN_INIT;
          cnt_d      = '0;
          state_d    = S_DIVN;
        end else begin
          cmd_o.code = CMD_GCD;
        end
      end
      S_DIVN: begin
        cmd_o.code = CMD_DIV_STEP;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CW'(PW - 1)) state_d = S_DIVD;
      end
      S_DIVD: begin
        // stores the numerator quotient and loads the denominator into the divider
        cmd_o.code = CMD_DIVD_INIT;
        cnt_d      = '0;
        state_d    = S_DDONE;
      end
      S_DDONE: begin
        cmd_o.code = CMD_DIV_STEP;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CW'(PW - 1)) begin
          state_d = S_DSTORE;
        end
      end
      S_DSTORE: begin
        // store the denominator quotient
        cmd_o.code = CMD_DIVD_DONE;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.code  = CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### sv/rau_dp.sv
// rau_dp: datapath of the rational arithmetic unit: multiplier, binary gcd,
// restoring divider and output word register; depends on rau_pkg
module rau_dp import rau_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic               clk_i,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic        [2:0]  opcode_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  output logic signed [31:0] res_num_o,
  output logic        [30:0] res_den_o,
  output logic        [1:0]  order_o,
  output logic        [1:0]  status_o
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;
  localparam int KW = $clog2(PW + 1);
  localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

  // sign and magnitude of the low W bits
  function automatic logic [W:0] split(input logic [31:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    return {v[W-1], (v[W-1] ? (~v + 1'b1) : v)};
  endfunction

  logic [2:0]    op_q;
  logic          sa_q, sb_q, err_q, dz_q;
  logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
  logic [PW-1:0] p0_q, p1_q, p2_q, p3_q;
  logic          rneg_q;
  logic [PW-1:0] rnum_q, rden_q;
  logic [PW-1:0] u_q, v_q, g_q;
  logic [KW-1:0] k_q;
  logic [PW-1:0] dq_q;
  logic [PW:0]   rem_q;
  logic [1:0]    order_q, status_q, ord_out_q;
  logic [31:0]   res_num_q;
  logic [30:0]   res_den_q;

  logic [W:0]    sp_an, sp_ad, sp_bn, sp_bd;
  logic [W-1:0]  mul_x, mul_y;
  logic [PW-1:0] prod;
  logic          sel_neg;
  logic [PW-1:0] sel_num, sel_den;
  logic          add_sy, sum_neg;
  logic [PW-1:0] sum_mag;
  logic [1:0]    ord_c;
  logic          cx, cy;
  logic [PW:0]   div_t;
  logic          div_ge;
  logic          ovf;
  logic [31:0]   num32;

  // operand split
  assign sp_an = split(a_num_i);
  assign sp_ad = split(a_den_i);
  assign sp_bn = split(b_num_i);
  assign sp_bd = split(b_den_i);

  // shared multiplier operands
  always_comb begin
    unique case (cmd_i.mul_sel)
      2'd0:    begin mul_x = an_q; mul_y = bd_q; end
      2'd1:    begin mul_x = bn_q; mul_y = ad_q; end
      2'd2:    begin mul_x = ad_q; mul_y = bd_q; end
      default: begin mul_x = an_q; mul_y = bn_q; end
    endcase
  end
  assign prod = PW'(mul_x) * PW'(mul_y);

  // signed magnitude sum of cross products
  always_comb begin
    add_sy = (op_q == OP_SUB) ? !sb_q : sb_q;
    if (sa_q == add_sy) begin
      sum_neg = sa_q;
      sum_mag = p0_q + p1_q;
    end else if (p0_q >= p1_q) begin
      sum_neg = sa_q;
      sum_mag = p0_q - p1_q;
    end else begin
      sum_neg = add_sy;
      sum_mag = p1_q - p0_q;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  // raw result per opcode
  always_comb begin
    unique case (op_q)
      OP_ADD, OP_SUB: begin sel_neg = sum_neg; sel_num = sum_mag; sel_den = p2_q; end
      OP_MUL: begin sel_neg = sa_q ^ sb_q; sel_num = p3_q; sel_den = p2_q; end
      OP_DIV: begin sel_neg = sa_q ^ sb_q; sel_num = p0_q; sel_den = p1_q; end
      OP_NEG: begin sel_neg = !sa_q; sel_num = PW'(an_q); sel_den = PW'(ad_q); end
      default: begin sel_neg = sa_q; sel_num = PW'(an_q); sel_den = PW'(ad_q); end
    endcase
  end

  // order of a against b from the cross products
  always_comb begin
    cx = sa_q && (p0_q != '0);
    cy = sb_q && (p1_q != '0);
    if (dz_q)                ord_c = ORD_EQUAL;
    else if (cx != cy)       ord_c = cx ? ORD_LESS : ORD_GREAT;
    else if (p0_q == p1_q)   ord_c = ORD_EQUAL;
    else if (!cx)            ord_c = (p0_q < p1_q) ? ORD_LESS : ORD_GREAT;
    else                     ord_c = (p0_q < p1_q) ? ORD_GREAT : ORD_LESS;
  end

  // restoring divider step
  assign div_t  = {rem_q[PW-1:0], dq_q[PW-1]};
  assign div_ge = (div_t >= {1'b0, g_q});

  // range check of the reduced result
  assign ovf   = (rden_q > (LIM - 1'b1)) || (rnum_q > (rneg_q ? LIM : (LIM - 1'b1)));
  assign num32 = 32'(rnum_q[W-1:0]);

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.code)
      CMD_LOAD: begin
        op_q  <= opcode_i;
        an_q  <= sp_an[W-1:0];
        ad_q  <= sp_ad[W-1:0];
        bn_q  <= sp_bn[W-1:0];
        bd_q  <= sp_bd[W-1:0];
        sa_q  <= (sp_an[W] != sp_ad[W]) && (sp_an[W-1:0] != '0);
        sb_q  <= (sp_bn[W] != sp_bd[W]) && (sp_bn[W-1:0] != '0);
        dz_q  <= (sp_ad[W-1:0] == '0) || (sp_bd[W-1:0] == '0);
        err_q <= (sp_ad[W-1:0] == '0)
              || ((opcode_i <= OP_DIV) && (sp_bd[W-1:0] == '0))
              || ((opcode_i == OP_DIV) && (sp_bn[W-1:0] == '0));
      end
      CMD_MUL: begin
        unique case (cmd_i.mul_sel)
          2'd0:    p0_q <= prod;
          2'd1:    p1_q <= prod;
          2'd2:    p2_q <= prod;
          default: p3_q <= prod;
        endcase
      end
      CMD_SEL: begin
        order_q <= ord_c;
        rneg_q  <= sel_neg;
        rnum_q  <= sel_num;
        rden_q  <= sel_den;
        u_q     <= sel_num;
        v_q     <= sel_den;
        k_q     <= '0;
      end
      CMD_GCD: begin
        // binary gcd step
        if (u_q == '0) begin
          u_q <= u_q;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= (u_q - v_q) >> 1;
        end else begin
          v_q <= (v_q - u_q) >> 1;
        end
      end
      CMD_DIVN_INIT: begin
        g_q   <= v_q << k_q;
        dq_q  <= rnum_q;
        rem_q <= '0;
      end
      CMD_DIV_STEP: begin
        dq_q  <= {dq_q[PW-2:0], div_ge};
        rem_q <= div_ge ? (div_t - {1'b0, g_q}) : div_t;
      end
      CMD_DIVD_INIT: begin
        rnum_q <= dq_q;
        dq_q   <= rden_q;
        rem_q  <= '0;
      end
      CMD_DIVD_DONE: begin
        rden_q <= dq_q;
      end
      default: begin end
    endcase
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.code == CMD_OUT) begin
      ord_out_q <= order_q;
      if (err_q) begin
        status_q  <= ST_ZERO;
        res_num_q <= '0;
        res_den_q <= 31'd1;
      end else if (ovf) begin
        status_q  <= ST_OVF;
        res_num_q <= '0;
        res_den_q <= 31'd1;
      end else begin
        status_q  <= ST_OK;
        res_num_q <= (rneg_q && (rnum_q != '0)) ? (~num32 + 1'b1) : num32;
        res_den_q <= 31'(rden_q[W-2:0]);
      end
    end
  end

  assign stat_o.err      = err_q;
  assign stat_o.gcd_done = (u_q == '0);

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign order_o   = ord_out_q;
  assign status_o  = status_q;

endmodule

### sv/rational_arithmetic_unit.sv
// Rational arithmetic unit: adds, subtracts, multiplies or divides two fractions, or reduces
// or negates the first, and returns the gcd-reduced result with a positive denominator, the
// order of A against B and a status code. One word is worked on at a time. After an item is
// accepted the shared multiplier forms the cross products in turn, the select step picks the
// raw result, the binary gcd loop runs one binary gcd step per cycle, the divider is loaded,
// and the one-bit-per-cycle restoring divider divides first the numerator and then the
// denominator by the gcd before the word is written to the output register. The time per
// item is set by the gcd loop and the shared divider. An item flagged for a zero denominator
// or a division by zero skips both and goes from the select step straight to the output. A
// finished word sits in the output register while the next item is taken; a new word waits
// for a stalled one to leave, and the input is stalled from acceptance until the word is
// written to the output register. Depends on rau_pkg, rau_ctrl and rau_dp.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [2:0]  opcode_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] res_num_o,
  output logic        [30:0] res_den_o,
  output logic        [1:0]  order_o,
  output logic        [1:0]  status_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  rau_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // arithmetic datapath
  rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .opcode_i  (opcode_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .order_o   (order_o),
    .status_o  (status_o)
  );

`ifndef NO_ASSERTIONS
  // an accepted word keeps the input side busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // a delivered denominator is never zero
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (res_den_o != '0))
    else $error("zero result denominator");

  // error words carry 0/1
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> ((res_num_o == '0) && (res_den_o == 31'd1)))
    else $error("error word not 0/1");

  // zero is always 0/1
  a_zero_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (res_num_o == '0)) |-> (res_den_o == 31'd1))
    else $error("zero not reduced to 0/1");
`endif

endmodule
